@@ sv/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_WAIT    = 3'd0,
    MODE_STR     = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX1    = 3'd3,
    MODE_NEED_BS = 3'd4,
    MODE_NEED_U  = 3'd5,
    MODE_HEX2    = 3'd6
  } mode_t;

  typedef enum logic [3:0] {
    ST_BYTE         = 4'd0,
    ST_DONE         = 4'd1,
    ST_NO_QUOTE     = 4'd2,
    ST_UNTERM_ESC   = 4'd3,
    ST_SHORT_U      = 4'd4,
    ST_BAD_HEX      = 4'd5,
    ST_LONE_SURR    = 4'd6,
    ST_BAD_LOW      = 4'd7,
    ST_BAD_ESCAPE   = 4'd8,
    ST_UNTERM_STR   = 4'd9
  } status_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] BS_CODE   = 8'h08;
  localparam logic [7:0] FF_CODE   = 8'h0C;
  localparam logic [7:0] LF_CODE   = 8'h0A;
  localparam logic [7:0] CR_CODE   = 8'h0D;
  localparam logic [7:0] TAB_CODE  = 8'h09;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPPL_BASE    = 21'h10000;
  localparam logic [20:0] LIMIT_1BYTE   = 21'h80;
  localparam logic [20:0] LIMIT_2BYTE   = 21'h800;
  localparam logic [20:0] LIMIT_3BYTE   = 21'h10000;
  localparam logic [7:0]  LEAD_2BYTE    = 8'hC0;
  localparam logic [7:0]  LEAD_3BYTE    = 8'hE0;
  localparam logic [7:0]  LEAD_4BYTE    = 8'hF0;
  localparam logic [7:0]  CONT_BYTE     = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       last;
  } out_word_t;

  // All results caused by one input word.
  typedef struct packed {
    logic [2:0]      cnt;
    status_t         status;
    logic [3:0][7:0] bytes;
  } jsu_bundle_t;

  typedef struct packed {
    logic        push;
    jsu_bundle_t bundle;
  } jsu_push_t;

  // Returns {invalid, value} for one hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic jsu_bundle_t utf8_encode(input logic [20:0] cp);
    jsu_bundle_t b;
    b = '0;
    b.status = ST_BYTE;
    if (cp < LIMIT_1BYTE) begin
      b.cnt      = 3'd1;
      b.bytes[0] = cp[7:0];
    end else if (cp < LIMIT_2BYTE) begin
      b.cnt      = 3'd2;
      b.bytes[0] = LEAD_2BYTE | {3'b000, cp[10:6]};
      b.bytes[1] = CONT_BYTE | {2'b00, cp[5:0]};
    end else if (cp < LIMIT_3BYTE) begin
      b.cnt      = 3'd3;
      b.bytes[0] = LEAD_3BYTE | {4'b0000, cp[15:12]};
      b.bytes[1] = CONT_BYTE | {2'b00, cp[11:6]};
      b.bytes[2] = CONT_BYTE | {2'b00, cp[5:0]};
    end else begin
      b.cnt      = 3'd4;
      b.bytes[0] = LEAD_4BYTE | {5'b00000, cp[20:18]};
      b.bytes[1] = CONT_BYTE | {2'b00, cp[17:12]};
      b.bytes[2] = CONT_BYTE | {2'b00, cp[11:6]};
      b.bytes[3] = CONT_BYTE | {2'b00, cp[5:0]};
    end
    return b;
  endfunction

endpackage

@@ sv/json_string_unescape_utf8_unit.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Unescapes a JSON string literal one source byte per word, producing UTF-8.
//
//   channel | direction | payload              | handshake
//   in_     | input     | data_byte, buffer_end| in_valid / in_ready
//   out_    | output    | out_byte, status,last| out_valid / out_ready
//
// An input word is decoded in the cycle it is accepted and its results are
// registered into a two-entry bundle queue, behind any bundle still queued.
// One input word is taken per cycle while the output keeps up. A code point leaves
// as up to four words, one per cycle while out_ready is high, and the input
// stalls once both queue entries are occupied. Reset waits for an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jsu_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jsu_pkg::out_word_t out_data
);

  jsu_pkg::jsu_push_t push;
  logic               full;

  assign in_ready = !full;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_valid && in_ready),
    .in_word (in_data),
    .push_o  (push)
  );

  jsu_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/jsu_decode.sv @@
// ----------------------------------------------------------------------------
// jsu_decode
// Parser state and the per-word decode of escapes, surrogates and UTF-8.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  jsu_pkg::in_word_t in_word,
  output jsu_pkg::jsu_push_t push_o
);

  jsu_pkg::mode_t   mode_r, mode_nxt;
  logic [9:0]       hs_r, hs_nxt;
  logic [11:0]      acc_r, acc_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             perr_r, perr_nxt;

  logic [4:0]       digit;
  logic [15:0]      acc_full;
  logic             bad_any;
  logic             group_done;
  logic             do_fail;
  jsu_pkg::status_t fail_st;
  jsu_pkg::jsu_bundle_t bnd;
  logic [7:0]       b;

  assign b          = in_word.data_byte;
  assign digit      = jsu_pkg::hex_digit(b);
  assign acc_full   = {acc_r, digit[3:0]};
  assign bad_any    = perr_r | digit[4];
  assign group_done = (cnt_r == 2'd3);

  always_comb begin
    mode_nxt = mode_r;
    hs_nxt   = hs_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    perr_nxt = perr_r;
    do_fail  = 1'b0;
    fail_st  = jsu_pkg::ST_DONE;
    bnd      = '0;
    bnd.status = jsu_pkg::ST_BYTE;
    if (in_word.buffer_end) begin
      unique case (mode_r)
        jsu_pkg::MODE_WAIT: begin
        end
        jsu_pkg::MODE_STR: begin
          do_fail = 1'b1;
          fail_st = jsu_pkg::ST_UNTERM_STR;
        end
        jsu_pkg::MODE_ESC: begin
          do_fail = 1'b1;
          fail_st = jsu_pkg::ST_UNTERM_ESC;
        end
        jsu_pkg::MODE_HEX1: begin
          do_fail = 1'b1;
          fail_st = jsu_pkg::ST_SHORT_U;
        end
        default: begin
          do_fail = 1'b1;
          fail_st = jsu_pkg::ST_LONE_SURR;
        end
      endcase
    end else begin
      unique case (mode_r)
        jsu_pkg::MODE_WAIT: begin
          if (b == jsu_pkg::CH_QUOTE) begin
            mode_nxt = jsu_pkg::MODE_STR;
          end else begin
            do_fail = 1'b1;
            fail_st = jsu_pkg::ST_NO_QUOTE;
          end
        end
        jsu_pkg::MODE_STR: begin
          if (b == jsu_pkg::CH_QUOTE) begin
            do_fail = 1'b1;
            fail_st = jsu_pkg::ST_DONE;
          end else if (b == jsu_pkg::CH_BSLASH) begin
            mode_nxt = jsu_pkg::MODE_ESC;
          end else begin
            bnd.cnt      = 3'd1;
            bnd.bytes[0] = b;
          end
        end
        jsu_pkg::MODE_ESC: begin
          mode_nxt = jsu_pkg::MODE_STR;
          bnd.cnt  = 3'd1;
          case (b)
            jsu_pkg::CH_QUOTE:  bnd.bytes[0] = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSLASH: bnd.bytes[0] = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_SLASH:  bnd.bytes[0] = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:      bnd.bytes[0] = jsu_pkg::BS_CODE;
            jsu_pkg::CH_F:      bnd.bytes[0] = jsu_pkg::FF_CODE;
            jsu_pkg::CH_N:      bnd.bytes[0] = jsu_pkg::LF_CODE;
            jsu_pkg::CH_R:      bnd.bytes[0] = jsu_pkg::CR_CODE;
            jsu_pkg::CH_T:      bnd.bytes[0] = jsu_pkg::TAB_CODE;
            jsu_pkg::CH_U: begin
              bnd.cnt  = 3'd0;
              acc_nxt  = '0;
              cnt_nxt  = '0;
              perr_nxt = 1'b0;
              mode_nxt = jsu_pkg::MODE_HEX1;
            end
            default: begin
              bnd.cnt = 3'd0;
              do_fail = 1'b1;
              fail_st = jsu_pkg::ST_BAD_ESCAPE;
            end
          endcase
        end
        jsu_pkg::MODE_HEX1: begin
          acc_nxt  = acc_full[11:0];
          cnt_nxt  = cnt_r + 2'd1;
          perr_nxt = bad_any;
          if (group_done) begin
            if (bad_any) begin
              do_fail = 1'b1;
              fail_st = jsu_pkg::ST_BAD_HEX;
            end else if (acc_full >= jsu_pkg::HIGH_SURR_MIN &&
                         acc_full <= jsu_pkg::HIGH_SURR_MAX) begin
              hs_nxt   = acc_full[9:0];
              mode_nxt = jsu_pkg::MODE_NEED_BS;
            end else begin
              bnd      = jsu_pkg::utf8_encode({5'b00000, acc_full});
              mode_nxt = jsu_pkg::MODE_STR;
            end
          end
        end
        jsu_pkg::MODE_NEED_BS: begin
          if (b == jsu_pkg::CH_BSLASH) begin
            mode_nxt = jsu_pkg::MODE_NEED_U;
          end else begin
            do_fail = 1'b1;
            fail_st = jsu_pkg::ST_LONE_SURR;
          end
        end
        jsu_pkg::MODE_NEED_U: begin
          if (b == jsu_pkg::CH_U) begin
            acc_nxt  = '0;
            cnt_nxt  = '0;
            perr_nxt = 1'b0;
            mode_nxt = jsu_pkg::MODE_HEX2;
          end else begin
            do_fail = 1'b1;
            fail_st = jsu_pkg::ST_LONE_SURR;
          end
        end
        jsu_pkg::MODE_HEX2: begin
          acc_nxt  = acc_full[11:0];
          cnt_nxt  = cnt_r + 2'd1;
          perr_nxt = bad_any;
          if (group_done) begin
            if (bad_any) begin
              do_fail = 1'b1;
              fail_st = jsu_pkg::ST_BAD_HEX;
            end else if (acc_full < jsu_pkg::LOW_SURR_MIN ||
                         acc_full > jsu_pkg::LOW_SURR_MAX) begin
              do_fail = 1'b1;
              fail_st = jsu_pkg::ST_BAD_LOW;
            end else begin
              bnd      = jsu_pkg::utf8_encode(jsu_pkg::SUPPL_BASE +
                                              {1'b0, hs_r, acc_full[9:0]});
              mode_nxt = jsu_pkg::MODE_STR;
              hs_nxt   = '0;
            end
          end
        end
        default: begin
          do_fail = 1'b1;
          fail_st = jsu_pkg::ST_BYTE;
        end
      endcase
    end
    if (do_fail) begin
      mode_nxt = jsu_pkg::MODE_WAIT;
      hs_nxt   = '0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      perr_nxt = 1'b0;
      bnd      = '0;
      bnd.status = fail_st;
      // An unknown mode on a data byte only recovers and reports nothing.
      bnd.cnt  = (fail_st == jsu_pkg::ST_BYTE) ? 3'd0 : 3'd1;
    end
  end

  assign push_o.push   = take && (bnd.cnt != 3'd0);
  assign push_o.bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_WAIT;
      hs_r   <= '0;
      acc_r  <= '0;
      cnt_r  <= '0;
      perr_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      hs_r   <= hs_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      perr_r <= perr_nxt;
    end
  end

endmodule

@@ sv/jsu_out_queue.sv @@
// ----------------------------------------------------------------------------
// jsu_out_queue
// Two-entry queue of result bundles, emitted one output word at a time.
// ----------------------------------------------------------------------------
module jsu_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  jsu_pkg::jsu_push_t push_i,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output jsu_pkg::out_word_t out_data
);

  jsu_pkg::jsu_bundle_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       is_last;
  logic       pop;
  jsu_pkg::jsu_bundle_t head;

  assign head      = slot_r[rd_ptr_r];
  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign is_last   = ({1'b0, idx_r} == (head.cnt - 3'd1));
  assign pop       = out_valid && out_ready && is_last;

  assign out_data.out_byte = head.bytes[idx_r];
  assign out_data.status   = head.status;
  assign out_data.last     = is_last;

  always_comb begin
    wr_ptr_nxt = push_i.push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_i.push} - {1'b0, pop};
    idx_nxt    = idx_r;
    if (out_valid && out_ready) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
      idx_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      slot_r[wr_ptr_r] <= push_i.bundle;
    end
  end

endmodule
